### hdl/nnd_pkg.sv
// Nearest-neighbor downscaler: shared types and constants.
// No dependencies; used by nearest_neighbor_downscaler.
`timescale 1ns / 1ps

package nnd_pkg;

	localparam int REG_W = 13;
	localparam int PIX_W = 8;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SOURCE_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_SOURCE_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_TARGET_WIDTH  = 2'd2;
	localparam cfg_idx_t CFG_TARGET_HEIGHT = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

endpackage

### hdl/nearest_neighbor_downscaler.sv
// Nearest-neighbor downscaler, top level.
// Each word passes the input register, then the output register; while the
// output is stalled the word waits in the input register.
// Throughput: one word per cycle unless the output stalls; input register,
// one pass of counter and accumulator update logic, output register.
// Reset (arst_n, async, active low): sizes 1920x1080 -> 1920x1080, counters
// restart on frame_start and on the first word after reset or any cfg write.
// Depends on nnd_pkg.
`timescale 1ns / 1ps

module nearest_neighbor_downscaler #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  nnd_pkg::cfg_idx_t             cfg_index,
	input  logic [nnd_pkg::REG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // blue_in, green_in, red_in
	input  logic                          s_tuser,  // frame_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,  // red_out, green_out, blue_out
	output logic                          m_tlast,  // row_end
	output logic                          m_tuser   // frame_end
);

	localparam int CWW = $clog2(MAX_WIDTH + 1);
	localparam int CWH = $clog2(MAX_HEIGHT + 1);
	localparam int AWW = 2 * CWW + 1;
	localparam int AWH = 2 * CWH + 1;

	// configuration registers
	logic [nnd_pkg::REG_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic                      restart_q;

	// effective sizes
	logic [CWW-1:0] sw, tw;
	logic [CWH-1:0] sh, th;

	always_comb begin
		if (src_w_q == '0) begin
			sw = CWW'(1);
		end else if (int'(src_w_q) > MAX_WIDTH) begin
			sw = CWW'(MAX_WIDTH);
		end else begin
			sw = CWW'(src_w_q);
		end
		if (src_h_q == '0) begin
			sh = CWH'(1);
		end else if (int'(src_h_q) > MAX_HEIGHT) begin
			sh = CWH'(MAX_HEIGHT);
		end else begin
			sh = CWH'(src_h_q);
		end
		if (tgt_w_q == '0) begin
			tw = CWW'(1);
		end else if (int'(tgt_w_q) > int'(sw)) begin
			tw = sw;
		end else begin
			tw = CWW'(tgt_w_q);
		end
		if (tgt_h_q == '0) begin
			th = CWH'(1);
		end else if (int'(tgt_h_q) > int'(sh)) begin
			th = sh;
		end else begin
			th = CWH'(tgt_h_q);
		end
	end

	// input stage
	logic              valid_s1;
	nnd_pkg::rgb_t     pix_s1;
	logic              fstart_s1;
	logic              advance;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	// position state
	logic [CWW-1:0] sc_q, tc_q;
	logic [CWH-1:0] sr_q, tr_q;
	logic [AWW-1:0] cacc_q, clim_q;
	logic [AWH-1:0] racc_q, rlim_q;
	logic           rsel_q;

	logic           fire, restart;
	logic [CWW-1:0] sc, tc, tc_n;
	logic [CWH-1:0] sr, tr;
	logic [AWW-1:0] cacc, clim, cacc_n, sw2, tw2;
	logic [AWH-1:0] racc, rlim, sh2, th2;
	logic           rsel, rsel_n, keep, row_end, frame_end, row_wrap, frame_wrap;

	assign fire    = valid_s1 && advance;
	assign restart = restart_q || fstart_s1;
	assign sw2     = AWW'(sw) << 1;
	assign tw2     = AWW'(tw) << 1;
	assign sh2     = AWH'(sh) << 1;
	assign th2     = AWH'(th) << 1;

	always_comb begin
		sc   = restart ? '0 : sc_q;
		tc   = restart ? '0 : tc_q;
		sr   = restart ? '0 : sr_q;
		tr   = restart ? '0 : tr_q;
		cacc = restart ? AWW'(sw) : cacc_q;
		clim = restart ? tw2 : clim_q;
		racc = restart ? AWH'(sh) : racc_q;
		rlim = restart ? th2 : rlim_q;
		rsel = restart ? 1'b0 : rsel_q;

		rsel_n = (sc == '0) ? ((tr < th) && (racc < rlim)) : rsel;
		keep   = rsel_n && (tc < tw) && (cacc < clim);

		row_end   = (tc == sw - sw + tw - CWW'(1));
		frame_end = row_end && (tr == th - CWH'(1));

		tc_n   = keep ? tc + CWW'(1) : tc;
		cacc_n = keep ? cacc + sw2 : cacc;

		row_wrap   = (CWW'(sc + CWW'(1)) >= sw);
		frame_wrap = (CWH'(sr + CWH'(1)) >= sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= nnd_pkg::REG_W'(1920);
			src_h_q   <= nnd_pkg::REG_W'(1080);
			tgt_w_q   <= nnd_pkg::REG_W'(1920);
			tgt_h_q   <= nnd_pkg::REG_W'(1080);
			restart_q <= 1'b1;
			valid_s1  <= 1'b0;
			m_tvalid  <= 1'b0;
			sc_q      <= '0;
			tc_q      <= '0;
			sr_q      <= '0;
			tr_q      <= '0;
			cacc_q    <= '0;
			clim_q    <= '0;
			racc_q    <= '0;
			rlim_q    <= '0;
			rsel_q    <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				m_tvalid <= fire && keep;
			end

			if (fire) begin
				restart_q <= 1'b0;
				rsel_q    <= rsel_n;
				if (row_wrap) begin
					sc_q   <= '0;
					tc_q   <= '0;
					cacc_q <= AWW'(sw);
					clim_q <= tw2;
					if (frame_wrap) begin
						sr_q   <= '0;
						tr_q   <= '0;
						racc_q <= AWH'(sh);
						rlim_q <= th2;
					end else begin
						sr_q   <= sr + CWH'(1);
						tr_q   <= rsel_n ? tr + CWH'(1) : tr;
						racc_q <= rsel_n ? racc + sh2 : racc;
						rlim_q <= rlim + th2;
					end
				end else begin
					sc_q   <= sc + CWW'(1);
					tc_q   <= tc_n;
					cacc_q <= cacc_n;
					clim_q <= clim + tw2;
					sr_q   <= sr;
					tr_q   <= tr;
					racc_q <= racc;
					rlim_q <= rlim;
				end
			end

			if (cfg_we) begin
				restart_q <= 1'b1;
				case (cfg_index)
					nnd_pkg::CFG_SOURCE_WIDTH:  src_w_q <= cfg_data;
					nnd_pkg::CFG_SOURCE_HEIGHT: src_h_q <= cfg_data;
					nnd_pkg::CFG_TARGET_WIDTH:  tgt_w_q <= cfg_data;
					nnd_pkg::CFG_TARGET_HEIGHT: tgt_h_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	nnd_pkg::rgb_t out_q;
	logic          last_q, user_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_s1.blue  <= s_tdata[7:0];
			pix_s1.green <= s_tdata[15:8];
			pix_s1.red   <= s_tdata[23:16];
			fstart_s1    <= s_tuser;
		end
		if (advance) begin
			out_q  <= pix_s1;
			last_q <= row_end;
			user_q <= frame_end;
		end
	end

	assign m_tdata = {out_q.blue, out_q.green, out_q.red};
	assign m_tlast = last_q;
	assign m_tuser = user_q;

	// frame end only on the last word of a row
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without row end");

	// target column never passes the target width
	assert property (@(posedge clk) disable iff (!arst_n)
		!restart_q |-> tc_q <= tw)
		else $error("target column out of range");

	// source column stays inside the row
	assert property (@(posedge clk) disable iff (!arst_n)
		!restart_q |-> sc_q < sw)
		else $error("source column out of range");

	// a stalled output holds the pending input word
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |=> valid_s1 && $stable(pix_s1))
		else $error("input stage lost a word under stall");

endmodule

### tb/nnd_downscale_check.sv
// Checker for nearest_neighbor_downscaler: watches the register port and both
// stream channels, predicts the kept pixels and compares each output word.
// Depends on nnd_pkg.
`timescale 1ns / 1ps

module nnd_downscale_check #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  nnd_pkg::cfg_idx_t         cfg_index,
	input  logic [nnd_pkg::REG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [23:0]               s_tdata,  // blue_in, green_in, red_in
	input  logic                      s_tuser,  // frame_start
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [23:0]               m_tdata,  // red_out, green_out, blue_out
	input  logic                      m_tlast,  // row_end
	input  logic                      m_tuser,  // frame_end
	output int                        fail_count,
	output int                        pending
);

	typedef logic [nnd_pkg::REG_W-1:0] dim_t;

	typedef struct packed {
		logic [nnd_pkg::PIX_W-1:0] red;
		logic [nnd_pkg::PIX_W-1:0] green;
		logic [nnd_pkg::PIX_W-1:0] blue;
		logic                      row_end;
		logic                      frame_end;
	} kept_pixel_t;

	kept_pixel_t kept_q[$];

	dim_t src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
	dim_t src_col, src_row, tgt_col, tgt_row;
	logic [25:0] col_acc, row_acc;
	logic row_kept;

	function automatic dim_t clamp_size(input dim_t v, input dim_t hi);
		if (v == '0)
			return dim_t'(1);
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic dim_t active_src_w();
		return clamp_size(src_w_reg, dim_t'(MAX_WIDTH));
	endfunction

	function automatic dim_t active_src_h();
		return clamp_size(src_h_reg, dim_t'(MAX_HEIGHT));
	endfunction

	function automatic dim_t active_tgt_w();
		return clamp_size(tgt_w_reg, active_src_w());
	endfunction

	function automatic dim_t active_tgt_h();
		return clamp_size(tgt_h_reg, active_src_h());
	endfunction

	function automatic void rewind_position();
		src_col  = '0;
		src_row  = '0;
		tgt_col  = '0;
		tgt_row  = '0;
		col_acc  = 26'(active_src_w());
		row_acc  = 26'(active_src_h());
		row_kept = 1'b0;
	endfunction

	// Centre of target column c sits at numerator (2c+1)*sw; the source column
	// holding it is the first one whose end (s+1)*2*tw lies beyond it.
	function automatic void predict_pixel(input logic [23:0] word, input logic first);
		dim_t sw, sh, tw, th;
		logic keep;
		kept_pixel_t px;
		sw = active_src_w();
		sh = active_src_h();
		tw = active_tgt_w();
		th = active_tgt_h();
		if (first)
			rewind_position();
		if (src_col == '0)
			row_kept = (tgt_row < th) &&
				(32'(row_acc) < (32'(src_row) + 1) * 2 * 32'(th));
		keep = row_kept && (tgt_col < tw) &&
			(32'(col_acc) < (32'(src_col) + 1) * 2 * 32'(tw));
		if (keep) begin
			px.red       = word[23:16];
			px.green     = word[15:8];
			px.blue      = word[7:0];
			px.row_end   = (tgt_col == tw - 1);
			px.frame_end = px.row_end && (tgt_row == th - 1);
			kept_q.push_back(px);
			tgt_col++;
			col_acc += 26'(2 * 32'(sw));
		end
		src_col++;
		if (src_col >= sw) begin
			src_col = '0;
			tgt_col = '0;
			col_acc = 26'(sw);
			if (row_kept) begin
				tgt_row++;
				row_acc += 26'(2 * 32'(sh));
			end
			src_row++;
			if (src_row >= sh) begin
				src_row = '0;
				tgt_row = '0;
				row_acc = 26'(sh);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
		input logic [23:0] want);
		fail_count++;
		if (fail_count <= 200)
			$display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		kept_pixel_t want;
		if (!arst_n) begin
			src_w_reg  = dim_t'(1920);
			src_h_reg  = dim_t'(1080);
			tgt_w_reg  = dim_t'(1920);
			tgt_h_reg  = dim_t'(1080);
			fail_count = 0;
			rewind_position();
			kept_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (kept_q.size() == 0) begin
					report_mismatch("unexpected word", m_tdata, '0);
				end else begin
					want = kept_q.pop_front();
					if (m_tdata[7:0] != want.red)
						report_mismatch("red", 24'(m_tdata[7:0]), 24'(want.red));
					if (m_tdata[15:8] != want.green)
						report_mismatch("green", 24'(m_tdata[15:8]), 24'(want.green));
					if (m_tdata[23:16] != want.blue)
						report_mismatch("blue", 24'(m_tdata[23:16]), 24'(want.blue));
					if (m_tlast != want.row_end)
						report_mismatch("row_end", 24'(m_tlast), 24'(want.row_end));
					if (m_tuser != want.frame_end)
						report_mismatch("frame_end", 24'(m_tuser), 24'(want.frame_end));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					nnd_pkg::CFG_SOURCE_WIDTH:  src_w_reg = cfg_data;
					nnd_pkg::CFG_SOURCE_HEIGHT: src_h_reg = cfg_data;
					nnd_pkg::CFG_TARGET_WIDTH:  tgt_w_reg = cfg_data;
					nnd_pkg::CFG_TARGET_HEIGHT: tgt_h_reg = cfg_data;
					default: ;
				endcase
				rewind_position();
			end
			if (s_tvalid && s_tready)
				predict_pixel(s_tdata, s_tuser);
		end
		pending = kept_q.size();
	end

endmodule

### tb/tb_nearest_neighbor_downscaler.sv
// Testbench top for nearest_neighbor_downscaler: clock, reset, register writes,
// pixel stimulus with random idling and a long output stall, and the verdict.
// Depends on nnd_pkg, nearest_neighbor_downscaler and nnd_downscale_check.
`timescale 1ns / 1ps

module tb_nearest_neighbor_downscaler;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	nnd_pkg::cfg_idx_t          cfg_index;
	logic [nnd_pkg::REG_W-1:0]  cfg_data;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [23:0]                s_tdata;
	logic                       s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [23:0]                m_tdata;
	logic                       m_tlast;
	logic                       m_tuser;

	int fail_count;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int pixels_sent = 0;

	nearest_neighbor_downscaler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	nnd_downscale_check check_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output side: random backpressure, plus a long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("nearest_neighbor_downscaler verification failed");
		$finish;
	end

	task automatic send_word(input logic [23:0] pix, input logic first);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			s_tuser  <= 1'($urandom_range(1));
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic send_frame(input int count, input int mid_start_pct, input bit lead_start);
		for (int i = 0; i < count; i++)
			send_word(24'($urandom),
				(i == 0 && lead_start) || ($urandom_range(99) < mid_start_pct));
	endtask

	// Writes only land once the pipeline holds nothing, dropped pixels included.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input nnd_pkg::cfg_idx_t idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= nnd_pkg::REG_W'(val);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_sizes(input int sw, input int sh, input int tw, input int th);
		wait_drained();
		write_reg(nnd_pkg::CFG_SOURCE_WIDTH, sw);
		write_reg(nnd_pkg::CFG_SOURCE_HEIGHT, sh);
		write_reg(nnd_pkg::CFG_TARGET_WIDTH, tw);
		write_reg(nnd_pkg::CFG_TARGET_HEIGHT, th);
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int goal);
		int sw, sh, tw, th, kind, len;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (pixels_sent < goal) begin
			if ($urandom_range(11) == 0) begin
				// full register range, mostly clamped or huge frames: partial stretch only
				set_sizes($urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191), $urandom_range(8191));
				send_frame($urandom_range(10, 40), 0, 1'b1);
			end else begin
				sw = $urandom_range(1, 12);
				sh = $urandom_range(1, 8);
				tw = $urandom_range(0, sw + 3);
				th = $urandom_range(0, sh + 3);
				set_sizes(sw, sh, tw, th);
				len = sw * sh;
				repeat ($urandom_range(1, 4)) begin
					kind = $urandom_range(99);
					if (kind < 75)
						send_frame(len, 0, 1'b1);
					else if (kind < 85)
						send_frame(len + $urandom_range(1, len), 0, 1'b0);
					else if (kind < 93)
						send_frame($urandom_range(1, len), 0, 1'b1);
					else
						send_frame(len, 6, 1'b1);
				end
			end
		end
	endtask

	initial begin
		int drain_cycles;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = nnd_pkg::CFG_SOURCE_WIDTH;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 31;
		rx_idle_pct = 47;

		// reset sizes, extreme pixel values
		send_word(24'h000000, 1'b1);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'h000000, 1'b0);
		send_word(24'hFFFFFF, 1'b1);

		// zero and oversized sizes clamp; one-pixel rows
		set_sizes(0, 8191, 0, 5000);
		send_word(24'hFFFFFF, 1'b1);
		send_word(24'h000000, 1'b0);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'h000000, 1'b0);

		// upscale saturates, zero height counts as one; wrap, then mid-frame start
		set_sizes(3, 2, 7, 0);
		send_frame(7, 0, 1'b0);
		send_frame(3, 0, 1'b1);

		// widest row, every pixel kept
		set_sizes(4096, 1, 4096, 1);
		send_frame(5, 0, 1'b1);

		run_phase(31, 47, 400);
		run_phase(47, 31, 780);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_sizes(8, 8, 8, 8);
		hold_requests++;
		send_frame(64, 0, 1'b1);

		run_phase(0, 0, 1150);

		s_tvalid <= 1'b0;
		for (drain_cycles = 0; pending != 0 && drain_cycles < 5000; drain_cycles++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("nearest_neighbor_downscaler verification clean");
		end else begin
			$display("nearest_neighbor_downscaler verification failed");
		end
		$finish;
	end

endmodule
